FILE: src/ordered_value_list_defines.svh
// Assertion macros used by the port-level checker of the ordered value list.
`ifndef ORDERED_VALUE_LIST_DEFINES_SVH
`define ORDERED_VALUE_LIST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OVL_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OVL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/ovl_pkg.sv
// Package with the item types, codes and control structs of the ordered value list.
`timescale 1ns / 1ps

package ovl_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } ovl_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } ovl_out_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } ovl_cmd_t;

    typedef struct packed {
        logic need_walk;
        logic hit;
        logic last;
        logic search;
    } ovl_stat_t;

endpackage

FILE: src/ovl_ctrl.sv
// Controller state machine that sequences load, walk when needed, and finish for each item.
`timescale 1ns / 1ps

module ovl_ctrl
    import ovl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output ovl_cmd_t  cmd,
    input  ovl_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.need_walk ? S_WALK : S_FINISH;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.last || (stat.hit && stat.search))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

FILE: src/ovl_datapath.sv
// Datapath with the entry memory, the walk pointers, the entry count and the result register.
`timescale 1ns / 1ps

module ovl_datapath
    import ovl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ovl_in_t   request,
    input  ovl_cmd_t  cmd,
    output ovl_stat_t stat,
    output ovl_out_t  result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   mem [DEPTH];

    logic [1:0]    req_reg;
    logic [31:0]   value_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] p_reg;
    logic [CW-1:0] p_next;
    logic [AW-1:0] q_reg;
    logic [AW-1:0] q_next;
    logic          rd_valid_reg;
    logic          rd_valid_next;
    logic [31:0]   rdata_reg;
    logic          found_reg;
    logic          found_next;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    ovl_out_t      result_reg;
    ovl_out_t      result_next;

    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          hit;
    logic          q_last;
    logic [1:0]    fin_status;
    logic [AW-1:0] fin_pos;

    assign hit    = rd_valid_reg && !found_reg && (rdata_reg == value_reg);
    assign q_last = ((CW'(q_reg) + CW'(1)) == count_reg);

    assign stat.need_walk = (request.req_type inside {REQ_REMOVE, REQ_SEARCH})
                            && (count_reg != '0);
    assign stat.hit       = hit;
    assign stat.last      = rd_valid_reg && q_last;
    assign stat.search    = (req_reg == REQ_SEARCH);

    always_comb
    begin
        count_next    = count_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        rd_valid_next = rd_valid_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        result_next   = result_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = q_reg - AW'(1);
        wr_data       = rdata_reg;
        fin_status    = STATUS_OK;
        fin_pos       = '0;

        if (cmd.load)
        begin
            p_next        = '0;
            rd_valid_next = 1'b0;
            found_next    = 1'b0;
        end

        if (cmd.walk)
        begin
            rd_en         = (p_reg < count_reg);
            rd_valid_next = rd_en;
            if (rd_en)
            begin
                p_next = p_reg + CW'(1);
                q_next = p_reg[AW-1:0];
            end
            if (hit)
            begin
                found_next = 1'b1;
                pos_next   = q_reg;
            end
            if (rd_valid_reg && found_reg && (req_reg == REQ_REMOVE))
            begin
                wr_en = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            case (req_reg)
                REQ_INSERT:
                begin
                    if (count_reg == CW'(DEPTH))
                    begin
                        fin_status = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = value_reg;
                        fin_pos    = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_REMOVE, REQ_SEARCH:
                begin
                    if (count_reg == '0)
                    begin
                        fin_status = STATUS_EMPTY;
                    end
                    else if (!found_reg)
                    begin
                        fin_status = STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        fin_pos = pos_reg;
                        if (req_reg == REQ_REMOVE)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                    fin_status = STATUS_OK;
                end
            endcase
            result_next.status      = fin_status;
            result_next.position    = 4'(fin_pos);
            result_next.entry_count = 5'(count_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[p_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= request.req_type;
            value_reg <= request.value;
        end
        q_reg      <= q_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            p_reg        <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            p_reg        <= p_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: src/ordered_value_list.sv
// Top level of the ordered value list: controller and datapath joined by command and status.
//
// A request item (insert at tail, remove first match, search) is accepted at a rising
// clock edge where start is high and busy is low. Busy then stays high until the result
// item appears on result, marked by done for exactly one cycle.
// Insert, an unused request code, and remove or search on an empty list skip the walk
// and go from acceptance straight to the finish state. Remove and search walk the entry
// memory from the head, one entry per cycle through its single registered read port,
// over the entries up to the first match for a search, and all current entries for a
// remove or a miss. Remove closes the gap in the same walk, writing each later entry
// one place toward the head.
// A new item may be accepted in the same cycle in which the previous result is shown.
// Reset empties the list at once; the memory contents need no clearing.
// The receiver cannot stall: each result is taken in the cycle in which done is high.
`timescale 1ns / 1ps

module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ovl_in_t  request,
    output logic     done,
    output ovl_out_t result
);

    ovl_cmd_t  cmd;
    ovl_stat_t stat;

    ovl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    ovl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

FILE: src/ovl_checker.sv
// Port-level checker for the ordered value list and the bind that attaches it.
`timescale 1ns / 1ps
`include "ordered_value_list_defines.svh"

module ovl_checker
    import ovl_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input ovl_out_t result
);

    `OVL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy.")
    `OVL_ASSERT_NEXT(a_done_single, done, !done, "Result strobe lasted more than one cycle.")
    `OVL_ASSERT_NOW(a_done_after_busy, done, $past(busy), "Result shown without a busy item.")
    `OVL_ASSERT_NOW(a_fail_position, done && (result.status != STATUS_OK), result.position == 4'd0, "Failed request reported a nonzero position.")

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: dv/ordered_value_list_checker.sv
// Checker that predicts every ordered value list result item and compares it with the block.
`timescale 1ns / 1ps

module ordered_value_list_checker
    import ovl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  ovl_in_t  request,
    input  logic     done,
    input  ovl_out_t result,
    output int       fail_count,
    output int       pending,
    output int       checked
);

    logic [31:0] list_values [DEPTH];
    int unsigned list_len;
    ovl_out_t    expected_results [$];
    int          fails;
    int          compared;

    task automatic apply_request(input ovl_in_t req, output ovl_out_t res);
        int unsigned hit;
        int unsigned i;
        res.status   = STATUS_OK;
        res.position = '0;
        if (req.req_type == REQ_INSERT)
        begin
            if (list_len >= DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                list_values[list_len] = req.value;
                res.position = list_len[3:0];
                list_len++;
            end
        end
        else if (req.req_type == REQ_REMOVE || req.req_type == REQ_SEARCH)
        begin
            if (list_len == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                hit = list_len;
                for (i = 0; i < list_len && hit == list_len; i++)
                begin
                    if (list_values[i] == req.value)
                    begin
                        hit = i;
                    end
                end
                if (hit == list_len)
                begin
                    res.status = STATUS_NOT_FOUND;
                end
                else
                begin
                    res.position = hit[3:0];
                    if (req.req_type == REQ_REMOVE)
                    begin
                        for (i = hit; i + 1 < list_len; i++)
                        begin
                            list_values[i] = list_values[i + 1];
                        end
                        list_len--;
                    end
                end
            end
        end
        res.entry_count = list_len[4:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ovl_out_t want;
        ovl_out_t next_want;
        if (!rst_n)
        begin
            list_len = 0;
            expected_results.delete();
            fails = 0;
            compared = 0;
            fail_count <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no request waiting: status %0d position %0d count %0d",
                           result.status, result.position, result.entry_count);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compared++;
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        fails++;
                    end
                    if (result.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, result.position);
                        fails++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, result.entry_count);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_request(request, next_want);
                expected_results.push_back(next_want);
            end
            fail_count <= fails;
            pending <= expected_results.size();
            checked <= compared;
        end
    end

endmodule

FILE: dv/ordered_value_list_tb.sv
// Testbench top for the ordered value list: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module ordered_value_list_tb;
    import ovl_pkg::*;

    localparam int DEPTH = 16;
    localparam int SEGMENTS = 17;
    localparam int SEGMENT_ITEMS = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     done;
    ovl_in_t  request = '0;
    ovl_out_t result;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int inserts_sent = 0;
    int removes_sent = 0;
    int searches_sent = 0;
    int unused_sent = 0;
    bit gap_free = 1'b0;

    always #5 clk = ~clk;

    ordered_value_list #(.DEPTH(DEPTH)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    ordered_value_list_checker #(.DEPTH(DEPTH)) list_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL ordered_value_list");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_free || roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= {kind, val};
        @(posedge clk);
        while (busy) @(posedge clk);
        case (kind)
            REQ_INSERT: inserts_sent++;
            REQ_REMOVE: removes_sent++;
            REQ_SEARCH: searches_sent++;
            default:    unused_sent++;
        endcase
    endtask

    initial
    begin
        logic [31:0] pool [8];
        int insert_pct;
        int roll;
        logic [1:0] kind;
        logic [31:0] val;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_SEARCH, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_UNUSED, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_SEARCH, 32'h7FFF_FFFF);
        send_request(REQ_SEARCH, 32'h0000_0005);
        send_request(REQ_REMOVE, 32'h0000_0005);
        send_request(REQ_REMOVE, 32'h7FFF_FFFF);
        send_request(REQ_SEARCH, 32'h7FFF_FFFF);
        send_request(REQ_UNUSED, 32'h7FFF_FFFF);
        send_request(REQ_REMOVE, 32'h8000_0000);
        send_request(REQ_REMOVE, 32'h7FFF_FFFF);
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            send_request(REQ_INSERT, 32'h1000_0000 + i);
        end
        send_request(REQ_INSERT, 32'h5555_AAAA);
        send_request(REQ_SEARCH, 32'h1000_000D);
        send_request(REQ_REMOVE, 32'h0000_0000);

        // Even segments lean toward inserts so the list fills; odd ones drain it.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            insert_pct = (seg % 2 == 0) ? 65 : 30;
            gap_free = ($urandom_range(0, 3) == 0);
            pool[0] = 32'h8000_0000;
            pool[1] = 32'h7FFF_FFFF;
            pool[2] = 32'h0000_0000;
            for (int p = 3; p < 8; p++)
            begin
                pool[p] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom;
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    kind = REQ_UNUSED;
                end
                else if (roll < 3 + insert_pct)
                begin
                    kind = REQ_INSERT;
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    kind = REQ_REMOVE;
                end
                else
                begin
                    kind = REQ_SEARCH;
                end
                val = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 7)] : $urandom;
                send_request(kind, val);
            end
        end

        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DEPTH + 5) @(posedge clk);

        $display("Sent %0d inserts, %0d removes, %0d searches and %0d unused codes;",
                 inserts_sent, removes_sent, searches_sent, unused_sent);
        $display("%0d result items compared, including full, empty and miss cases.", checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS ordered_value_list");
        end
        else
        begin
            $display("FAIL ordered_value_list");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/ovl_pkg.sv
src/ovl_ctrl.sv
src/ovl_datapath.sv
src/ordered_value_list.sv
src/ovl_checker.sv
dv/ordered_value_list_checker.sv
dv/ordered_value_list_tb.sv
